/* design/lbct_pkg.sv */
// Shared constants, types and codes for the LRU block cache tag engine.
`default_nettype none
package lbct_pkg;

  // Default sizing of the cache and the drive range.
  localparam int NUM_BUFFERS_DEF = 16;
  localparam int NUM_DRIVES_DEF  = 4;

  // Fixed field widths of the transaction payloads.
  localparam int PAGE_W   = 45;
  localparam int DRIVE_W  = 2;
  localparam int BUF_W    = 4;
  localparam int STATUS_W = 4;
  localparam int STAMP_W  = 64;
  localparam int TAG_W    = PAGE_W + DRIVE_W;

  // Function codes of an input transaction.
  typedef enum logic [1:0] {
    FN_LOOKUP = 2'd0,
    FN_FETCH  = 2'd1,
    FN_WRITE  = 2'd2,
    FN_INVAL  = 2'd3
  } func_t;

  // Status codes of a result transaction.
  localparam logic [STATUS_W-1:0] ST_HIT          = 4'd0;
  localparam logic [STATUS_W-1:0] ST_CLAIMED      = 4'd1;
  localparam logic [STATUS_W-1:0] ST_RETRY_BUSY   = 4'd2;
  localparam logic [STATUS_W-1:0] ST_RETRY_FULL   = 4'd3;
  localparam logic [STATUS_W-1:0] ST_FILLED       = 4'd4;
  localparam logic [STATUS_W-1:0] ST_FETCH_ERR    = 4'd5;
  localparam logic [STATUS_W-1:0] ST_RETRY_STALE  = 4'd6;
  localparam logic [STATUS_W-1:0] ST_PATCHED      = 4'd7;
  localparam logic [STATUS_W-1:0] ST_MARKED_STALE = 4'd8;
  localparam logic [STATUS_W-1:0] ST_NO_ENTRY     = 4'd9;
  localparam logic [STATUS_W-1:0] ST_INVALIDATED  = 4'd10;
  localparam logic [STATUS_W-1:0] ST_IGNORED      = 4'd11;
  localparam logic [STATUS_W-1:0] ST_BYPASS       = 4'd12;

  // Flags the scan unit reports to the sequencer.
  typedef struct packed {
    logic hit_found;  // a live entry matched the tag
    logic hit_busy;   // that first live match is still being fetched
    logic vic_found;  // some idle entry can be claimed
    logic vic_free;   // the chosen victim is idle and invalid
    logic drive_eq;   // the entry under evaluation belongs to the drive
  } scan_stat_t;

endpackage
`default_nettype wire

/* design/lru_block_cache_tags_core.sv */
// Top level of the LRU block cache tag and replacement engine.
//   The input channel (in_valid / in_stall) carries one request per
//   transaction: lookup, fetch done, write notify or drive invalidate.
//   The output channel (out_valid / out_stall) returns exactly one result
//   transaction per request, in order: status, entry index and evict flag.
//   cfg_wr_en / cfg_wr_data set the cache enable bit; write it only while
//   the engine is idle.
// Sequencing:
//   Lookup, write notify and invalidate on a valid drive scan all
//   NUM_BUFFERS entries, one per cycle, before the result is formed;
//   fetch done, bypass and ignored requests answer without a scan. Each
//   result passes through the output register, and a new request is taken
//   only once the result has moved there. in_stall is high while a
//   request is in work.
// Reset:
//   rst_n is synchronous and active low. It clears all valid, busy and
//   stale bits, the access clock and the output valid bit, and enables the
//   cache. The RAMs are not cleared: an entry's contents only matter once
//   it has been claimed. A stalled result holds in the output register
//   while the next request is processed up to its own result.
`default_nettype none
module lru_block_cache_tags_core #(
  parameter int NUM_BUFFERS = lbct_pkg::NUM_BUFFERS_DEF,
  parameter int NUM_DRIVES  = lbct_pkg::NUM_DRIVES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic                           cfg_wr_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [1:0]                     in_func,
  input  wire logic [lbct_pkg::DRIVE_W-1:0]   in_drive,
  input  wire logic [lbct_pkg::PAGE_W-1:0]    in_page,
  input  wire logic [lbct_pkg::BUF_W-1:0]     in_buffer_in,
  input  wire logic                           in_fetch_ok,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [lbct_pkg::STATUS_W-1:0]  out_status,
  output logic      [lbct_pkg::BUF_W-1:0]     out_buffer_out,
  output logic                                out_evicted
);

  localparam int AW = $clog2(NUM_BUFFERS);
  localparam int CW = $clog2(NUM_BUFFERS + 1);
  localparam logic [CW-1:0] NB_CNT = CW'(NUM_BUFFERS);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_FINISH = 4'b0100,
    S_OUT    = 4'b1000
  } state_t;

  state_t                           state_r, state_nxt;
  logic                             cfg_en_r;
  lbct_pkg::func_t                  q_func_r, q_func_nxt;
  logic [lbct_pkg::DRIVE_W-1:0]     q_drive_r, q_drive_nxt;
  logic [lbct_pkg::PAGE_W-1:0]      q_page_r, q_page_nxt;
  logic [CW-1:0]                    cnt_r, cnt_nxt;
  logic                             ev_vld_r, ev_vld_nxt;
  logic [AW-1:0]                    ev_idx_r, ev_idx_nxt;
  logic [NUM_BUFFERS-1:0]           valid_r, valid_nxt;
  logic [NUM_BUFFERS-1:0]           busy_r, busy_nxt;
  logic [NUM_BUFFERS-1:0]           stale_r, stale_nxt;
  logic [lbct_pkg::STAMP_W-1:0]     clock_r, clock_nxt;
  logic [lbct_pkg::STATUS_W-1:0]    res_status_r, res_status_nxt;
  logic [lbct_pkg::BUF_W-1:0]       res_buf_r, res_buf_nxt;
  logic                             res_evict_r, res_evict_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [lbct_pkg::STATUS_W-1:0]    out_status_r, out_status_nxt;
  logic [lbct_pkg::BUF_W-1:0]       out_buf_r, out_buf_nxt;
  logic                             out_evict_r, out_evict_nxt;

  logic [lbct_pkg::STAMP_W-1:0]     clock_inc;
  logic [AW-1:0]                    fidx;
  logic                             fidx_ok;
  logic                             drive_bad;
  logic                             tag_we;
  logic [AW-1:0]                    tag_waddr;
  logic [lbct_pkg::TAG_W-1:0]       tag_wdata;
  logic [lbct_pkg::TAG_W-1:0]       tag_rdata;
  logic                             stamp_we;
  logic [AW-1:0]                    stamp_waddr;
  logic [lbct_pkg::STAMP_W-1:0]     stamp_rdata;
  logic [AW-1:0]                    rd_addr;
  logic                             scan_clr;
  lbct_pkg::scan_stat_t             sc;
  logic [AW-1:0]                    hit_idx;
  logic [AW-1:0]                    vic_idx;

  assign clock_inc = clock_r + 64'd1;
  assign fidx      = AW'(in_buffer_in);
  assign fidx_ok   = 32'(in_buffer_in) < NUM_BUFFERS;
  assign drive_bad = 32'(in_drive) >= NUM_DRIVES;
  assign tag_wdata = {q_drive_r, q_page_r};
  assign rd_addr   = cnt_r[AW-1:0];

  // Tag RAM holds drive and page of each entry.
  lbct_ram #(
    .WIDTH (lbct_pkg::TAG_W),
    .DEPTH (NUM_BUFFERS)
  ) u_tag_ram (
    .clk     (clk),
    .wr_en   (tag_we),
    .wr_addr (tag_waddr),
    .wr_data (tag_wdata),
    .rd_addr (rd_addr),
    .rd_data (tag_rdata)
  );

  // Stamp RAM holds the last access time of each entry.
  lbct_ram #(
    .WIDTH (lbct_pkg::STAMP_W),
    .DEPTH (NUM_BUFFERS)
  ) u_stamp_ram (
    .clk     (clk),
    .wr_en   (stamp_we),
    .wr_addr (stamp_waddr),
    .wr_data (clock_inc),
    .rd_addr (rd_addr),
    .rd_data (stamp_rdata)
  );

  // Shared per-entry compare unit.
  lbct_scan #(
    .NUM_BUFFERS (NUM_BUFFERS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (scan_clr),
    .ev_vld    (ev_vld_r),
    .ev_idx    (ev_idx_r),
    .ent_page  (tag_rdata[lbct_pkg::PAGE_W-1:0]),
    .ent_drive (tag_rdata[lbct_pkg::TAG_W-1:lbct_pkg::PAGE_W]),
    .ent_stamp (stamp_rdata),
    .ent_valid (valid_r[ev_idx_r]),
    .ent_busy  (busy_r[ev_idx_r]),
    .q_page    (q_page_r),
    .q_drive   (q_drive_r),
    .stat      (sc),
    .hit_idx   (hit_idx),
    .vic_idx   (vic_idx)
  );

  // Sequencer and entry state updates.
  always_comb begin
    state_nxt      = state_r;
    q_func_nxt     = q_func_r;
    q_drive_nxt    = q_drive_r;
    q_page_nxt     = q_page_r;
    cnt_nxt        = cnt_r;
    ev_vld_nxt     = 1'b0;
    ev_idx_nxt     = ev_idx_r;
    valid_nxt      = valid_r;
    busy_nxt       = busy_r;
    stale_nxt      = stale_r;
    clock_nxt      = clock_r;
    res_status_nxt = res_status_r;
    res_buf_nxt    = res_buf_r;
    res_evict_nxt  = res_evict_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_buf_nxt    = out_buf_r;
    out_evict_nxt  = out_evict_r;
    tag_we         = 1'b0;
    tag_waddr      = vic_idx;
    stamp_we       = 1'b0;
    stamp_waddr    = hit_idx;
    scan_clr       = 1'b0;

    // The receiver takes the pending result.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          q_func_nxt    = lbct_pkg::func_t'(in_func);
          q_drive_nxt   = in_drive;
          q_page_nxt    = in_page;
          res_buf_nxt   = '0;
          res_evict_nxt = 1'b0;
          state_nxt     = S_OUT;
          if (!cfg_en_r) begin
            res_status_nxt = lbct_pkg::ST_BYPASS;
          end else if (lbct_pkg::func_t'(in_func) == lbct_pkg::FN_FETCH) begin
            // Fetch completion needs no scan: only the named entry changes.
            if (!fidx_ok || !busy_r[fidx]) begin
              res_status_nxt = lbct_pkg::ST_IGNORED;
            end else begin
              busy_nxt[fidx] = 1'b0;
              if (!in_fetch_ok) begin
                res_status_nxt = lbct_pkg::ST_FETCH_ERR;
              end else if (stale_r[fidx]) begin
                stale_nxt[fidx] = 1'b0;
                res_status_nxt  = lbct_pkg::ST_RETRY_STALE;
              end else begin
                clock_nxt       = clock_inc;
                stamp_we        = 1'b1;
                stamp_waddr     = fidx;
                valid_nxt[fidx] = 1'b1;
                res_status_nxt  = lbct_pkg::ST_FILLED;
                res_buf_nxt     = lbct_pkg::BUF_W'(fidx);
              end
            end
          end else if (drive_bad) begin
            res_status_nxt = lbct_pkg::ST_IGNORED;
          end else begin
            scan_clr  = 1'b1;
            cnt_nxt   = '0;
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Issue one RAM read per cycle; each entry is evaluated in the cycle after its read.
        if (cnt_r < NB_CNT) begin
          ev_vld_nxt = 1'b1;
          ev_idx_nxt = cnt_r[AW-1:0];
          cnt_nxt    = cnt_r + CW'(1);
        end else if (!ev_vld_r) begin
          state_nxt = S_FINISH;
        end
        // Drive invalidation clears entries as they pass.
        if (ev_vld_r && q_func_r == lbct_pkg::FN_INVAL && sc.drive_eq) begin
          valid_nxt[ev_idx_r] = 1'b0;
        end
      end

      S_FINISH: begin
        state_nxt = S_OUT;
        case (q_func_r)
          lbct_pkg::FN_LOOKUP: begin
            if (sc.hit_found) begin
              if (sc.hit_busy) begin
                res_status_nxt = lbct_pkg::ST_RETRY_BUSY;
              end else begin
                clock_nxt      = clock_inc;
                stamp_we       = 1'b1;
                stamp_waddr    = hit_idx;
                res_status_nxt = lbct_pkg::ST_HIT;
                res_buf_nxt    = lbct_pkg::BUF_W'(hit_idx);
              end
            end else if (!sc.vic_found) begin
              res_status_nxt = lbct_pkg::ST_RETRY_FULL;
            end else begin
              // Claim the victim and start its fetch.
              tag_we             = 1'b1;
              tag_waddr          = vic_idx;
              valid_nxt[vic_idx] = 1'b0;
              busy_nxt[vic_idx]  = 1'b1;
              stale_nxt[vic_idx] = 1'b0;
              res_status_nxt     = lbct_pkg::ST_CLAIMED;
              res_buf_nxt        = lbct_pkg::BUF_W'(vic_idx);
              res_evict_nxt      = !sc.vic_free;
            end
          end
          lbct_pkg::FN_WRITE: begin
            if (sc.hit_found) begin
              if (sc.hit_busy) begin
                stale_nxt[hit_idx] = 1'b1;
                res_status_nxt     = lbct_pkg::ST_MARKED_STALE;
              end else begin
                res_status_nxt = lbct_pkg::ST_PATCHED;
                res_buf_nxt    = lbct_pkg::BUF_W'(hit_idx);
              end
            end else begin
              res_status_nxt = lbct_pkg::ST_NO_ENTRY;
            end
          end
          lbct_pkg::FN_INVAL: begin
            res_status_nxt = lbct_pkg::ST_INVALIDATED;
          end
          default: begin
            res_status_nxt = lbct_pkg::ST_IGNORED;
          end
        endcase
      end

      S_OUT: begin
        // Move the result into the output register once it is free.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_buf_nxt    = res_buf_r;
          out_evict_nxt  = res_evict_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state with reset, payload without.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_en_r    <= 1'b1;
      cnt_r       <= '0;
      ev_vld_r    <= 1'b0;
      valid_r     <= '0;
      busy_r      <= '0;
      stale_r     <= '0;
      clock_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_wr_en) begin
        cfg_en_r <= cfg_wr_data;
      end
      cnt_r       <= cnt_nxt;
      ev_vld_r    <= ev_vld_nxt;
      valid_r     <= valid_nxt;
      busy_r      <= busy_nxt;
      stale_r     <= stale_nxt;
      clock_r     <= clock_nxt;
      out_valid_r <= out_valid_nxt;
    end
    q_func_r     <= q_func_nxt;
    q_drive_r    <= q_drive_nxt;
    q_page_r     <= q_page_nxt;
    ev_idx_r     <= ev_idx_nxt;
    res_status_r <= res_status_nxt;
    res_buf_r    <= res_buf_nxt;
    res_evict_r  <= res_evict_nxt;
    out_status_r <= out_status_nxt;
    out_buf_r    <= out_buf_nxt;
    out_evict_r  <= out_evict_nxt;
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_buffer_out = out_buf_r;
  assign out_evicted    = out_evict_r;

endmodule
`default_nettype wire

/* design/lbct_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module lbct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

/* design/lbct_scan.sv */
// Scan unit: evaluates one entry per cycle for tag match and victim choice.
`default_nettype none
module lbct_scan #(
  parameter int NUM_BUFFERS = lbct_pkg::NUM_BUFFERS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            clr,
  input  wire logic                            ev_vld,
  input  wire logic [$clog2(NUM_BUFFERS)-1:0]  ev_idx,
  input  wire logic [lbct_pkg::PAGE_W-1:0]     ent_page,
  input  wire logic [lbct_pkg::DRIVE_W-1:0]    ent_drive,
  input  wire logic [lbct_pkg::STAMP_W-1:0]    ent_stamp,
  input  wire logic                            ent_valid,
  input  wire logic                            ent_busy,
  input  wire logic [lbct_pkg::PAGE_W-1:0]     q_page,
  input  wire logic [lbct_pkg::DRIVE_W-1:0]    q_drive,
  output lbct_pkg::scan_stat_t                 stat,
  output logic      [$clog2(NUM_BUFFERS)-1:0]  hit_idx,
  output logic      [$clog2(NUM_BUFFERS)-1:0]  vic_idx
);

  localparam int AW = $clog2(NUM_BUFFERS);

  logic                         hit_found_r, hit_found_nxt;
  logic                         hit_busy_r, hit_busy_nxt;
  logic [AW-1:0]                hit_idx_r, hit_idx_nxt;
  logic                         vic_found_r, vic_found_nxt;
  logic                         vic_free_r, vic_free_nxt;
  logic [AW-1:0]                vic_idx_r, vic_idx_nxt;
  logic [lbct_pkg::STAMP_W-1:0] vic_stamp_r, vic_stamp_nxt;
  logic                         drive_eq;
  logic                         live;
  logic                         older;

  // Tag compare; an idle invalid entry never matches.
  assign drive_eq = (ent_drive == q_drive);
  assign live     = drive_eq && (ent_page == q_page) && (ent_busy || ent_valid);
  assign older    = (ent_stamp < vic_stamp_r);

  // Accumulate the first live match and the replacement victim.
  always_comb begin
    hit_found_nxt = hit_found_r;
    hit_busy_nxt  = hit_busy_r;
    hit_idx_nxt   = hit_idx_r;
    vic_found_nxt = vic_found_r;
    vic_free_nxt  = vic_free_r;
    vic_idx_nxt   = vic_idx_r;
    vic_stamp_nxt = vic_stamp_r;
    if (clr) begin
      hit_found_nxt = 1'b0;
      hit_busy_nxt  = 1'b0;
      vic_found_nxt = 1'b0;
      vic_free_nxt  = 1'b0;
    end else if (ev_vld) begin
      if (!hit_found_r && live) begin
        hit_found_nxt = 1'b1;
        hit_busy_nxt  = ent_busy;
        hit_idx_nxt   = ev_idx;
      end
      // The first idle invalid entry wins outright; before one shows up
      // the oldest idle valid entry is kept, lowest index on a tie.
      if (!ent_busy && !vic_free_r) begin
        if (!ent_valid) begin
          vic_found_nxt = 1'b1;
          vic_free_nxt  = 1'b1;
          vic_idx_nxt   = ev_idx;
        end else if (!vic_found_r || older) begin
          vic_found_nxt = 1'b1;
          vic_idx_nxt   = ev_idx;
          vic_stamp_nxt = ent_stamp;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_found_r <= 1'b0;
      hit_busy_r  <= 1'b0;
      vic_found_r <= 1'b0;
      vic_free_r  <= 1'b0;
    end else begin
      hit_found_r <= hit_found_nxt;
      hit_busy_r  <= hit_busy_nxt;
      vic_found_r <= vic_found_nxt;
      vic_free_r  <= vic_free_nxt;
    end
    hit_idx_r   <= hit_idx_nxt;
    vic_idx_r   <= vic_idx_nxt;
    vic_stamp_r <= vic_stamp_nxt;
  end

  assign stat.hit_found = hit_found_r;
  assign stat.hit_busy  = hit_busy_r;
  assign stat.vic_found = vic_found_r;
  assign stat.vic_free  = vic_free_r;
  assign stat.drive_eq  = drive_eq;
  assign hit_idx        = hit_idx_r;
  assign vic_idx        = vic_idx_r;

endmodule
`default_nettype wire

/* design/lbct_checker.sv */
// Port-level checker for the cache tag engine and its bind to the top level.
`default_nettype none
module lbct_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_stall,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic [lbct_pkg::STATUS_W-1:0]  out_status,
  input wire logic [lbct_pkg::BUF_W-1:0]     out_buffer_out,
  input wire logic                           out_evicted
);

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_buffer_out) && $stable(out_evicted))
    else $error("stalled result changed");

  // Only one request is in work: acceptance closes the input channel.
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while a request is in work");

  // Reset empties the output register.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Only a miss claim can report an eviction.
  a_evict_claim: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted |-> out_status == lbct_pkg::ST_CLAIMED)
    else $error("eviction flagged without a claim");

  // Results that name no entry carry index zero.
  a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != lbct_pkg::ST_HIT
      && out_status != lbct_pkg::ST_CLAIMED
      && out_status != lbct_pkg::ST_FILLED
      && out_status != lbct_pkg::ST_PATCHED |-> out_buffer_out == '0)
    else $error("entry index set on a result without an entry");

endmodule

bind lru_block_cache_tags_core lbct_checker u_lbct_checker (.*);
`default_nettype wire
